### hdl/nccs_pkg.sv
// Package for the nearest cube color search block: command codes, controller states,
// the level table and the window edge helpers. No dependencies.
package nccs_pkg;

   // Request kinds, carried on req_tuser.
   typedef enum logic [1:0] {
      CMD_WR_CELL  = 2'd0,
      CMD_WR_PAL   = 2'd1,
      CMD_QUERY    = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_DRAIN  = 5'b10000
   } state_type;

   localparam int unsigned CUBE_DEPTH = 512;
   localparam int unsigned CUBE_AW    = 9;
   localparam logic [2:0]  CUBE_MAX   = 3'd7;
   localparam int unsigned DIST_W     = 18;

   // Reference color level for a cube index.
   function automatic logic [7:0] level_of(input logic [2:0] idx);
      logic [7:0] lvl;
      unique case (idx)
         3'd0: lvl = 8'd0;
         3'd1: lvl = 8'd36;
         3'd2: lvl = 8'd73;
         3'd3: lvl = 8'd109;
         3'd4: lvl = 8'd146;
         3'd5: lvl = 8'd182;
         3'd6: lvl = 8'd219;
         3'd7: lvl = 8'd255;
         default: lvl = 8'd0;
      endcase
      return lvl;
   endfunction

   // Low edge of the window on one axis, clamped at zero.
   function automatic logic [2:0] lo_edge(input logic [2:0] c, input logic [2:0] r);
      logic [2:0] e;
      e = (c > r) ? (c - r) : 3'd0;
      return e;
   endfunction

   // High edge of the window on one axis, clamped at the cube's last index.
   function automatic logic [2:0] hi_edge(input logic [2:0] c, input logic [2:0] r);
      logic [3:0] s;
      s = {1'b0, c} + {1'b0, r};
      return (s > {1'b0, CUBE_MAX}) ? CUBE_MAX : s[2:0];
   endfunction

   // Squared distance between two 8-bit components.
   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

endpackage

### hdl/nearest_cube_color_search_top.sv
// Top level of the nearest cube color search block: cube and palette memories,
// scan controller and match pipeline. Depends on nccs_pkg.
//
// Channel   Dir  Handshake                Contents
// req_      in   req_tvalid/req_tready    tuser: command; tdata: cell, palette entry, radius
// rsp_      out  rsp_tvalid/rsp_tready    tuser: found flag; tdata: nearest palette index
//
// After reset the block clears both memories in one pass, one cube cell a cycle,
// with req_tready low for that time.
// A cell or palette write passes its result through the pending register to the output register.
// A query scans windows of growing radius; each window is set up in the load state, then
// scanned one cube cell a cycle (the single read port of the cube memory), and then the
// match pipeline drains; the result then passes through the pending register to the
// output register.
// The block works on one request at a time. A finished result sits in the output
// register while the next request is accepted; a stalled rsp_ side holds the next
// result in the controller until the register frees up.

module nearest_cube_color_search_top #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] cell_red, [5:3] cell_green, [8:6] cell_blue, [16:9] pixel_index,
   // [24:17] entry_red, [32:25] entry_green, [40:33] entry_blue,
   // [43:41] start_radius, [47:44] zero
   input  logic [47:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] nearest_pixel
   output logic [7:0]  rsp_tdata,
   // [0] found
   output logic        rsp_tuser
);

   localparam int unsigned PAL_AW    = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0]  PAL_LIMIT = 9'(PALETTE_ENTRIES);

   // Request fields.
   logic [2:0] req_cell_red;
   logic [2:0] req_cell_green;
   logic [2:0] req_cell_blue;
   logic [7:0] req_pixel_index;
   logic [7:0] req_entry_red;
   logic [7:0] req_entry_green;
   logic [7:0] req_entry_blue;
   logic [2:0] req_start_radius;
   nccs_pkg::cmd_type req_cmd;
   logic       req_accept;

   assign req_cell_red     = req_tdata[2:0];
   assign req_cell_green   = req_tdata[5:3];
   assign req_cell_blue    = req_tdata[8:6];
   assign req_pixel_index  = req_tdata[16:9];
   assign req_entry_red    = req_tdata[24:17];
   assign req_entry_green  = req_tdata[32:25];
   assign req_entry_blue   = req_tdata[40:33];
   assign req_start_radius = req_tdata[43:41];
   assign req_cmd          = nccs_pkg::cmd_type'(req_tuser);

   // Controller registers.
   nccs_pkg::state_type state_ff, state_in;
   logic [8:0] clr_cnt_ff, clr_cnt_in;
   logic [2:0] ctr_r_ff, ctr_g_ff, ctr_b_ff;
   logic [2:0] ctr_r_in, ctr_g_in, ctr_b_in;
   logic [2:0] radius_ff, radius_in;
   logic [2:0] scan_i_ff, scan_j_ff, scan_k_ff;
   logic [2:0] scan_i_in, scan_j_in, scan_k_in;
   logic       pend_ff, pend_in;         // a finished result waits for the output register
   logic [7:0] pend_pixel_ff, pend_pixel_in;
   logic       pend_found_ff, pend_found_in;

   // Window bounds for the current radius.
   logic [2:0] lo_i, lo_j, lo_k, hi_i, hi_j, hi_k;
   logic       scan_last;

   assign lo_i = nccs_pkg::lo_edge(ctr_r_ff, radius_ff);
   assign lo_j = nccs_pkg::lo_edge(ctr_g_ff, radius_ff);
   assign lo_k = nccs_pkg::lo_edge(ctr_b_ff, radius_ff);
   assign hi_i = nccs_pkg::hi_edge(ctr_r_ff, radius_ff);
   assign hi_j = nccs_pkg::hi_edge(ctr_g_ff, radius_ff);
   assign hi_k = nccs_pkg::hi_edge(ctr_b_ff, radius_ff);
   assign scan_last = (scan_i_ff == hi_i) && (scan_j_ff == hi_j) && (scan_k_ff == hi_k);

   // Match pipeline registers.
   logic        p1_vld_ff, p1_vld_in;
   logic        p2_vld_ff, p2_vld_in;
   logic        p3_vld_ff, p3_vld_in;
   logic [7:0]  p2_idx_ff;
   logic        p2_inrange_ff;
   logic [7:0]  p3_idx_ff;
   logic [15:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic        have_ff, have_in;
   logic [nccs_pkg::DIST_W-1:0] best_d_ff, best_d_in;
   logic [7:0]  best_idx_ff, best_idx_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_ff, rsp_pixel_in;
   logic       rsp_found_ff, rsp_found_in;
   logic       rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == nccs_pkg::ST_IDLE) && !pend_ff;
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------------------------
   // Memories. The cube holds palette indices, the palette holds {red, green, blue}.
   // ---------------------------------------------------------------------------------
   logic [7:0]  cube_mem [nccs_pkg::CUBE_DEPTH];
   logic [23:0] pal_mem  [PALETTE_ENTRIES];

   logic                        cube_we;
   logic [nccs_pkg::CUBE_AW-1:0] cube_waddr, cube_raddr;
   logic [7:0]                  cube_wdata, cube_rd_ff;
   logic                        pal_we;
   logic [PAL_AW-1:0]           pal_waddr, pal_raddr;
   logic [23:0]                 pal_wdata, pal_rd_ff;

   always_comb begin
      if (state_ff == nccs_pkg::ST_CLEAR) begin
         cube_we    = 1'b1;
         cube_waddr = clr_cnt_ff;
         cube_wdata = 8'd0;
         pal_we     = clr_cnt_ff < PAL_LIMIT;
         pal_waddr  = clr_cnt_ff[PAL_AW-1:0];
         pal_wdata  = 24'd0;
      end else begin
         cube_we    = req_accept && (req_cmd == nccs_pkg::CMD_WR_CELL);
         cube_waddr = {req_cell_red, req_cell_green, req_cell_blue};
         cube_wdata = req_pixel_index;
         pal_we     = req_accept && (req_cmd == nccs_pkg::CMD_WR_PAL)
                      && ({1'b0, req_pixel_index} < PAL_LIMIT);
         pal_waddr  = req_pixel_index[PAL_AW-1:0];
         pal_wdata  = {req_entry_red, req_entry_green, req_entry_blue};
      end
   end

   assign cube_raddr = {scan_i_ff, scan_j_ff, scan_k_ff};
   assign pal_raddr  = cube_rd_ff[PAL_AW-1:0];

   always_ff @(posedge clock) begin
      if (cube_we) begin
         cube_mem[cube_waddr] <= cube_wdata;
      end
      cube_rd_ff <= cube_mem[cube_raddr];
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_waddr] <= pal_wdata;
      end
      pal_rd_ff <= pal_mem[pal_raddr];
   end

   // ---------------------------------------------------------------------------------
   // Match pipeline: cube data -> palette read -> squared differences -> compare.
   // ---------------------------------------------------------------------------------
   logic [7:0]  ref_r, ref_g, ref_b;
   logic [23:0] p2_color;
   logic [nccs_pkg::DIST_W-1:0] p3_dist;

   assign ref_r    = nccs_pkg::level_of(ctr_r_ff);
   assign ref_g    = nccs_pkg::level_of(ctr_g_ff);
   assign ref_b    = nccs_pkg::level_of(ctr_b_ff);
   // An index beyond the palette reads as black.
   assign p2_color = p2_inrange_ff ? pal_rd_ff : 24'd0;
   assign p3_dist  = nccs_pkg::DIST_W'(sq_r_ff) + nccs_pkg::DIST_W'(sq_g_ff)
                     + nccs_pkg::DIST_W'(sq_b_ff);

   assign p1_vld_in = (state_ff == nccs_pkg::ST_SCAN);
   assign p2_vld_in = p1_vld_ff && (cube_rd_ff != 8'd0);
   assign p3_vld_in = p2_vld_ff;

   always_ff @(posedge clock) begin
      p2_idx_ff     <= cube_rd_ff;
      p2_inrange_ff <= {1'b0, cube_rd_ff} < PAL_LIMIT;
      p3_idx_ff     <= p2_idx_ff;
      sq_r_ff       <= nccs_pkg::sq_diff(p2_color[23:16], ref_r);
      sq_g_ff       <= nccs_pkg::sq_diff(p2_color[15:8], ref_g);
      sq_b_ff       <= nccs_pkg::sq_diff(p2_color[7:0], ref_b);
   end

   // Best match so far; the first strict minimum is kept.
   always_comb begin
      have_in     = have_ff;
      best_d_in   = best_d_ff;
      best_idx_in = best_idx_ff;
      if (state_ff == nccs_pkg::ST_LOAD) begin
         have_in = 1'b0;
      end else if (p3_vld_ff && (!have_ff || (p3_dist < best_d_ff))) begin
         have_in     = 1'b1;
         best_d_in   = p3_dist;
         best_idx_in = p3_idx_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Controller.
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      ctr_r_in      = ctr_r_ff;
      ctr_g_in      = ctr_g_ff;
      ctr_b_in      = ctr_b_ff;
      radius_in     = radius_ff;
      scan_i_in     = scan_i_ff;
      scan_j_in     = scan_j_ff;
      scan_k_in     = scan_k_ff;
      pend_in       = pend_ff;
      pend_pixel_in = pend_pixel_ff;
      pend_found_in = pend_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_found_in  = rsp_found_ff;

      // A waiting result moves to the output register as soon as it is free.
      if (pend_ff && rsp_free) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_pixel_in = pend_pixel_ff;
         rsp_found_in = pend_found_ff;
      end

      unique case (state_ff)
         nccs_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 9'd1;
            if (clr_cnt_ff == 9'(nccs_pkg::CUBE_DEPTH - 1)) begin
               state_in = nccs_pkg::ST_IDLE;
            end
         end
         nccs_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == nccs_pkg::CMD_QUERY) begin
                  ctr_r_in  = req_cell_red;
                  ctr_g_in  = req_cell_green;
                  ctr_b_in  = req_cell_blue;
                  radius_in = req_start_radius;
                  state_in  = nccs_pkg::ST_LOAD;
               end else begin
                  // Writes and the unused command answer zero.
                  pend_in       = 1'b1;
                  pend_pixel_in = 8'd0;
                  pend_found_in = 1'b0;
               end
            end
         end
         nccs_pkg::ST_LOAD: begin
            scan_i_in = lo_i;
            scan_j_in = lo_j;
            scan_k_in = lo_k;
            state_in  = nccs_pkg::ST_SCAN;
         end
         nccs_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = nccs_pkg::ST_DRAIN;
            end else if (scan_k_ff != hi_k) begin
               scan_k_in = scan_k_ff + 3'd1;
            end else begin
               scan_k_in = lo_k;
               if (scan_j_ff != hi_j) begin
                  scan_j_in = scan_j_ff + 3'd1;
               end else begin
                  scan_j_in = lo_j;
                  scan_i_in = scan_i_ff + 3'd1;
               end
            end
         end
         nccs_pkg::ST_DRAIN: begin
            // Decide once the last cell of the window has passed the compare stage.
            if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff) begin
               if (have_ff || (radius_ff == nccs_pkg::CUBE_MAX)) begin
                  pend_in       = 1'b1;
                  pend_pixel_in = have_ff ? best_idx_ff : 8'd0;
                  pend_found_in = have_ff;
                  state_in      = nccs_pkg::ST_IDLE;
               end else begin
                  radius_in = radius_ff + 3'd1;
                  state_in  = nccs_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = nccs_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nccs_pkg::ST_CLEAR;
         clr_cnt_ff   <= 9'd0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         p3_vld_ff    <= p3_vld_in;
         have_ff      <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_r_ff      <= ctr_r_in;
      ctr_g_ff      <= ctr_g_in;
      ctr_b_ff      <= ctr_b_in;
      radius_ff     <= radius_in;
      scan_i_ff     <= scan_i_in;
      scan_j_ff     <= scan_j_in;
      scan_k_ff     <= scan_k_in;
      pend_pixel_ff <= pend_pixel_in;
      pend_found_ff <= pend_found_in;
      best_d_ff     <= best_d_in;
      best_idx_ff   <= best_idx_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_found_ff;

   // ---------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------
   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

   a_idle_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == nccs_pkg::ST_IDLE) |-> !(p1_vld_ff || p2_vld_ff || p3_vld_ff))
      else $error("match pipeline busy while idle");

   a_scan_in_window : assert property (@(posedge clock) disable iff (reset)
      (state_ff == nccs_pkg::ST_SCAN) |->
         (scan_i_ff >= lo_i) && (scan_i_ff <= hi_i) && (scan_j_ff >= lo_j)
         && (scan_j_ff <= hi_j) && (scan_k_ff >= lo_k) && (scan_k_ff <= hi_k))
      else $error("scan position outside the window");

   a_found_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_pixel_ff != 8'd0))
      else $error("found result names the empty index");

endmodule
